### rtl/spd_pkg.sv
//------------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the shortest path engine.
//------------------------------------------------------------------------------
package spd_pkg;

	localparam int NODE_COUNT    = 256;
	localparam int EDGE_COUNT    = 1024;
	localparam int WEIGHT_BITS   = 16;
	localparam int DISTANCE_BITS = 24;
	localparam int NODE_BITS     = $clog2(NODE_COUNT);
	localparam int EDGE_BITS     = $clog2(EDGE_COUNT);
	localparam int LINK_BITS     = EDGE_BITS + 1;

	localparam logic [DISTANCE_BITS-1:0] DIST_MAX = '1;
	localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(EDGE_COUNT);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_RUN   = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  node;
		logic [7:0]  edge_target;
		logic [15:0] weight;
	} in_beat_t;

	typedef struct packed {
		logic        status;
		logic [23:0] distance;
		logic        reached;
		logic [7:0]  predecessor;
		logic        has_predecessor;
	} out_beat_t;

	typedef struct packed {
		logic [DISTANCE_BITS-1:0] path_len;
		logic                     reached;
		logic                     settled;
		logic [NODE_BITS-1:0]     prev;
		logic                     prev_valid;
	} node_rec_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]   dst;
		logic [WEIGHT_BITS-1:0] cost;
		logic [LINK_BITS-1:0]   link;
	} edge_rec_t;

	localparam int NODE_REC_BITS = $bits(node_rec_t);
	localparam int EDGE_REC_BITS = $bits(edge_rec_t);
	localparam int LIST_REC_BITS = 2 * LINK_BITS;

endpackage

### rtl/shortest_path_dijkstra.sv
// A query reads the node record and returns it as the reply; an add writes the
// new edge and the list head and tail, and an add to a node that already holds
// edges also reads, modifies and writes back the old tail's link; an add to a
// full store is answered with status set and writes nothing. A clear and every
// run first sweep over the per-node memories (list heads for a clear, node
// records for a run); a run then, per settled node, scans all node records for
// the minimum, settles it and fetches its list head, then for each outgoing
// edge reads the edge and does a read-modify-write through the single read port
// of the node memory, and checks once more at the end of the list. After reset
// a sweep initializes list and node memories, during which stall is high.
//------------------------------------------------------------------------------
// shortest_path_dijkstra
// Dijkstra single-source shortest path engine over memory-held graph state.
//------------------------------------------------------------------------------
module shortest_path_dijkstra
	import spd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_QRD, ST_ARD, ST_LWR, ST_SCAN_RD, ST_SCAN, ST_SETTLE,
		ST_EHEAD, ST_ERD, ST_NRD, ST_NWR, ST_LCLR, ST_NCLR, ST_DONE
	} state_t;

	state_t state_q;
	logic [NODE_BITS:0]     cnt_q;
	logic [EDGE_BITS:0]     used_q;
	in_beat_t               cmd_q;
	logic [NODE_BITS-1:0]   best_q;
	logic                   best_ok_q;
	logic [DISTANCE_BITS-1:0] best_d_q;
	logic [NODE_BITS-1:0]   best_prev_q;
	logic                   best_pv_q;
	logic [LINK_BITS-1:0]   e_q;
	edge_rec_t              edge_q;
	logic                   out_valid_q;
	out_beat_t              out_q;
	logic [EDGE_BITS-1:0]   link_addr_q;
	logic [LINK_BITS-1:0]   link_val_q;

	logic                     n_we, l_we, e_we;
	logic [NODE_BITS-1:0]     n_wa, n_ra, l_wa, l_ra;
	node_rec_t                n_wd, n_rd;
	logic [LIST_REC_BITS-1:0] l_wd, l_rd;
	logic [EDGE_BITS-1:0]     e_wa, e_ra;
	edge_rec_t                e_wd, e_rd;
	logic [NODE_REC_BITS-1:0] n_rd_raw;
	logic [EDGE_REC_BITS-1:0] e_rd_raw;
	logic [LINK_BITS-1:0]     l_head, l_tail;
	logic [DISTANCE_BITS:0]   sum;
	logic [DISTANCE_BITS-1:0] sum_sat;
	logic                     out_free;
	logic                     add_full;
	logic                     out_set;

	assign n_rd = node_rec_t'(n_rd_raw);
	assign e_rd = edge_rec_t'(e_rd_raw);
	assign l_head = l_rd[LIST_REC_BITS-1:LINK_BITS];
	assign l_tail = l_rd[LINK_BITS-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign sum = {1'b0, best_d_q} + (DISTANCE_BITS+1)'(edge_q.cost);
	assign sum_sat = sum[DISTANCE_BITS] ? DIST_MAX : sum[DISTANCE_BITS-1:0];
	assign add_full = (in_data.op == OP_ADD) && (used_q >= (EDGE_BITS+1)'(EDGE_COUNT));
	assign out_set = ((state_q == ST_IDLE) && in_valid && out_free && add_full) ||
		((state_q == ST_DONE) && out_free);

	spd_ram #(.WIDTH(NODE_REC_BITS), .DEPTH(NODE_COUNT)) u_node (
		.clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd_raw)
	);
	spd_ram #(.WIDTH(LIST_REC_BITS), .DEPTH(NODE_COUNT)) u_list (
		.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	spd_ram #(.WIDTH(EDGE_REC_BITS), .DEPTH(EDGE_COUNT)) u_edge (
		.clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd_raw)
	);

	always_comb begin
		n_we = 1'b0;
		n_wa = cnt_q[NODE_BITS-1:0];
		n_wd = '{path_len: DIST_MAX, reached: 1'b0, settled: 1'b0,
			prev: '0, prev_valid: 1'b0};
		n_ra = in_data.node;
		l_we = 1'b0;
		l_wa = cnt_q[NODE_BITS-1:0];
		l_wd = {NULL_LINK, NULL_LINK};
		l_ra = in_data.node;
		e_we = 1'b0;
		e_wa = used_q[EDGE_BITS-1:0];
		e_wd = '{dst: cmd_q.edge_target, cost: cmd_q.weight, link: NULL_LINK};
		e_ra = e_q[EDGE_BITS-1:0];
		unique case (state_q)
			ST_INIT: begin
				n_we = 1'b1;
				l_we = 1'b1;
			end
			ST_LCLR: l_we = 1'b1;
			ST_NCLR: begin
				n_we = 1'b1;
				if (cnt_q[NODE_BITS-1:0] == cmd_q.node) begin
					n_wd.path_len = '0;
					n_wd.reached = 1'b1;
				end
			end
			ST_ARD: begin
				e_we = 1'b1;
				e_ra = l_tail[EDGE_BITS-1:0];
				l_we = 1'b1;
				l_wa = cmd_q.node;
				l_wd = {(l_head == NULL_LINK) ? LINK_BITS'(used_q) : l_head,
					LINK_BITS'(used_q)};
			end
			ST_LWR: begin
				e_we = 1'b1;
				e_wa = link_addr_q;
				e_wd = '{dst: e_rd.dst, cost: e_rd.cost, link: link_val_q};
			end
			ST_SCAN_RD, ST_SCAN: n_ra = cnt_q[NODE_BITS-1:0];
			ST_SETTLE: begin
				n_we = best_ok_q;
				n_wa = best_q;
				n_wd = '{path_len: best_d_q, reached: 1'b1, settled: 1'b1,
					prev: best_prev_q, prev_valid: best_pv_q};
				l_ra = best_q;
			end
			ST_NRD: n_ra = e_rd.dst;
			ST_NWR: begin
				n_wa = edge_q.dst;
				n_wd = '{path_len: sum_sat, reached: 1'b1, settled: 1'b0,
					prev: best_q, prev_valid: 1'b1};
				n_we = !n_rd.settled && (sum_sat < n_rd.path_len);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && out_stall);
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (NODE_BITS+1)'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && out_free) begin
						cmd_q <= in_data;
						out_q <= '{status: add_full, distance: '0, reached: 1'b0,
							predecessor: '0, has_predecessor: 1'b0};
						cnt_q <= '0;
						unique case (op_t'(in_data.op))
							OP_ADD: begin
								if (!add_full) begin
									state_q <= ST_ARD;
								end
							end
							OP_RUN: state_q <= ST_NCLR;
							OP_QUERY: state_q <= ST_QRD;
							OP_CLEAR: state_q <= ST_LCLR;
							default: ;
						endcase
					end
				end
				ST_QRD: begin
					out_q <= '{status: 1'b0, distance: n_rd.path_len, reached: n_rd.reached,
						predecessor: n_rd.prev, has_predecessor: n_rd.prev_valid};
					state_q <= ST_DONE;
				end
				ST_ARD: begin
					used_q <= used_q + 1'b1;
					link_addr_q <= l_tail[EDGE_BITS-1:0];
					link_val_q <= LINK_BITS'(used_q);
					if (l_head != NULL_LINK) begin
						state_q <= ST_LWR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_LWR: state_q <= ST_DONE;
				ST_LCLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (NODE_BITS+1)'(NODE_COUNT - 1)) begin
						used_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_NCLR: begin
					if (cnt_q == (NODE_BITS+1)'(NODE_COUNT - 1)) begin
						cnt_q <= '0;
						best_ok_q <= 1'b0;
						state_q <= ST_SCAN_RD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (n_rd.reached && !n_rd.settled &&
						(!best_ok_q || n_rd.path_len < best_d_q)) begin
						best_ok_q <= 1'b1;
						best_q <= cnt_q[NODE_BITS-1:0];
						best_d_q <= n_rd.path_len;
						best_prev_q <= n_rd.prev;
						best_pv_q <= n_rd.prev_valid;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (NODE_BITS+1)'(NODE_COUNT - 1)) begin
						state_q <= ST_SETTLE;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SETTLE: begin
					if (!best_ok_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_EHEAD;
					end
				end
				ST_EHEAD: begin
					e_q <= l_head;
					state_q <= ST_ERD;
				end
				ST_ERD: begin
					if (e_q >= LINK_BITS'(used_q)) begin
						cnt_q <= '0;
						best_ok_q <= 1'b0;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_NRD;
					end
				end
				ST_NRD: begin
					edge_q <= e_rd;
					state_q <= ST_NWR;
				end
				ST_NWR: begin
					e_q <= edge_q.link;
					state_q <= ST_ERD;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/spd_ram.sv
//------------------------------------------------------------------------------
// spd_ram
// Single-port write, single-port read RAM with registered read data.
//------------------------------------------------------------------------------
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
